// ===== rtl/rcwc_pkg.sv =====
package rcwc_pkg;

  typedef struct packed {
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic [15:0]        robot_heading;
    logic [13:0]        distance_mm;
    logic [5:0]         confidence;
  } rcwc_in_t;

  typedef struct packed {
    logic [1:0]         coord_kind;
    logic signed [15:0] coord_value;
    logic [2:0]         wall_hit;
  } rcwc_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z;
    logic               neg;
  } rcwc_rot_t;

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [13:0]        dist_mm;
    logic               rej;
  } rcwc_side_t;

  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_X       = 2'd1;
  localparam logic [1:0] KIND_Y       = 2'd2;

  localparam logic [2:0] WALL_NONE  = 3'd0;
  localparam logic [2:0] WALL_NORTH = 3'd1;
  localparam logic [2:0] WALL_EAST  = 3'd2;
  localparam logic [2:0] WALL_SOUTH = 3'd3;
  localparam logic [2:0] WALL_WEST  = 3'd4;

  localparam logic [2:0] REG_MOUNT_DIST  = 3'd0;
  localparam logic [2:0] REG_MOUNT_ANGLE = 3'd1;
  localparam logic [2:0] REG_RAY_ANGLE   = 3'd2;
  localparam logic [2:0] REG_ANGLE_TOL   = 3'd3;
  localparam logic [2:0] REG_MAX_DIST    = 3'd4;
  localparam logic [2:0] REG_MIN_CONF    = 3'd5;
  localparam logic [2:0] REG_FIELD_HALF  = 3'd6;

  localparam logic [13:0]        LOW_CONF_MM = 14'd200;
  localparam logic [30:0]        TRIG_EPS    = 31'd1073;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  function automatic logic [31:0] atan_turn32(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933405;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10680862;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335086;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41721;
      15: a = 32'd20860;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2607;
      19: a = 32'd1303;
      20: a = 32'd651;
      21: a = 32'd325;
      22: a = 32'd162;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/raycast_wall_coordinate_unit.sv =====
// channel | signals                       | transaction
// --------+-------------------------------+-------------------------------------
// in      | in_valid, in_stall, in_data   | one reading with pose estimate
// out     | out_valid, out_stall, out_data| one coordinate result per reading
// cfg     | cfg_we, cfg_addr, cfg_wdata   | one register write, no read-back
//
// One reading enters per cycle while in_stall is low; each reading passes the front checks,
// the CORDIC cell row (one rotation step per cell on each of its two vectors), the wall test
// and the divide-by-127 stages before its result is valid.
// Synchronous active-low reset clears the stage valid bits and sets the config registers to their defaults.
// Every stage holds its transaction while the next stage is full and held; bubbles close up, so
// input is taken while a finished result waits on out_stall as long as a stage is empty.
module raycast_wall_coordinate_unit import rcwc_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16,
  parameter int COORD_FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rcwc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rcwc_out_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  localparam int NC = ANGLE_ITERATIONS;
  localparam int F  = COORD_FRAC_BITS;
  localparam int PB = 5 + NC;
  localparam int NS = PB + 16;
  localparam int CW = 7 + F;
  localparam int RW = 52 + F;

  typedef struct packed {
    logic               rej;
    logic [2:0]         wall;
    logic               tneg;
    logic signed [15:0] wallpos;
    logic signed [48:0] projoff;
  } tail_t;

  logic [15:0] mount_dist_r, mount_angle_r;
  logic [16:0] ray_angle_r;
  logic [12:0] angle_tol_r;
  logic [13:0] max_dist_r;
  logic [5:0]  min_conf_r;
  logic [14:0] field_half_r;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_dist_r  <= 16'd0;
      mount_angle_r <= 16'd0;
      ray_angle_r   <= 17'd0;
      angle_tol_r   <= 13'd500;
      max_dist_r    <= 14'd2000;
      min_conf_r    <= 6'd32;
      field_half_r  <= 15'd18048;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MOUNT_DIST:  mount_dist_r  <= cfg_wdata[15:0];
        REG_MOUNT_ANGLE: mount_angle_r <= cfg_wdata[15:0];
        REG_RAY_ANGLE:   ray_angle_r   <= cfg_wdata;
        REG_ANGLE_TOL:   angle_tol_r   <= cfg_wdata[12:0];
        REG_MAX_DIST:    max_dist_r    <= cfg_wdata[13:0];
        REG_MIN_CONF:    min_conf_r    <= cfg_wdata[5:0];
        REG_FIELD_HALF:  field_half_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NS-1];

  function automatic logic [15:0] wrap36k(input logic signed [17:0] v);
    logic [18:0] t;
    t = 19'(19'(v) + 19'sd72000);
    for (int i = 0; i < 5; i++) begin
      if (t >= 19'd36000) t = t - 19'd36000;
    end
    return t[15:0];
  endfunction

  function automatic logic signed [18:0] rnd30(input logic signed [48:0] p);
    logic signed [48:0] t;
    t = p + 49'sd536870912;
    return 19'(t >>> 30);
  endfunction

  // front: checks and angle sums
  rcwc_side_t         sd0_r, sd1_r, sd2_r, sd3_r, sd4_r;
  rcwc_side_t         sd2_nxt;
  logic signed [17:0] s1_r, s2_r;
  logic [15:0]        h1_r, d21_r;
  logic [15:0]        m_val;
  logic               rej0_nxt, rej2_nxt;

  always_comb begin
    rej0_nxt = (in_data.distance_mm == 14'd0) || (in_data.distance_mm > max_dist_r) ||
               ((in_data.distance_mm > LOW_CONF_MM) && (in_data.confidence < min_conf_r));
    m_val = h1_r;
    for (int i = 0; i < 4; i++) begin
      if (m_val >= 16'd9000) m_val = m_val - 16'd9000;
    end
    rej2_nxt = sd1_r.rej || ((m_val > 16'(angle_tol_r)) &&
                             (m_val < 16'd9000 - 16'(angle_tol_r)));
    sd2_nxt = sd1_r;
    sd2_nxt.rej = rej2_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sd0_r.rx      <= in_data.robot_x;
      sd0_r.ry      <= in_data.robot_y;
      sd0_r.dist_mm <= in_data.distance_mm;
      sd0_r.rej     <= rej0_nxt;
      s1_r <= $signed({2'b0, in_data.robot_heading}) + $signed({ray_angle_r[16], ray_angle_r});
      s2_r <= $signed({2'b0, mount_angle_r}) - $signed({2'b0, in_data.robot_heading});
    end
    if (rdy[1]) begin
      sd1_r <= sd0_r;
      h1_r  <= wrap36k(s1_r);
      d21_r <= wrap36k(s2_r);
    end
    if (rdy[2]) sd2_r <= sd2_nxt;
    if (rdy[3]) sd3_r <= sd2_r;
    if (rdy[4]) sd4_r <= sd3_r;
  end

  logic signed [32:0] zr_w, zo_w;
  logic               nr_w, no_w;

  rcwc_turn u_turn_ray (
    .clk(clk), .en1(rdy[2]), .en2(rdy[3]), .en3(rdy[4]),
    .d(h1_r), .z(zr_w), .neg(nr_w)
  );

  rcwc_turn u_turn_off (
    .clk(clk), .en1(rdy[2]), .en2(rdy[3]), .en3(rdy[4]),
    .d(d21_r), .z(zo_w), .neg(no_w)
  );

  rcwc_rot_t  ra_w [0:NC];
  rcwc_rot_t  rb_w [0:NC];
  rcwc_side_t rs_w [0:NC];

  assign ra_w[0] = '{x: CORDIC_GAIN, y: 32'sd0, z: zr_w, neg: nr_w};
  assign rb_w[0] = '{x: CORDIC_GAIN, y: 32'sd0, z: zo_w, neg: no_w};
  assign rs_w[0] = sd4_r;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    rcwc_cordic_cell #(.I(g)) u_cell (
      .clk(clk), .en(rdy[5+g]),
      .a_in(ra_w[g]), .b_in(rb_w[g]), .side_in(rs_w[g]),
      .a_out(ra_w[g+1]), .side_out(rs_w[g+1]), .b_out(rb_w[g+1])
    );
  end

  // back end: wall test and coordinate recovery
  rcwc_side_t         psd_r [0:5];
  logic signed [31:0] ch_r [0:4];
  logic signed [31:0] sh_r [0:4];
  logic signed [31:0] co0_r, so0_r;
  logic signed [48:0] pco_r [1:4];
  logic signed [48:0] pso_r [1:4];
  logic signed [19:0] sxq_r, syq_r;
  logic [20:0]        anx3_r, any3_r;
  logic               okx_r [3:4];
  logic               oky_r [3:4];
  logic [2:0]         wx_r [3:4];
  logic [2:0]         wy_r [3:4];
  logic [51:0]        prx_r, pry_r;
  logic signed [31:0] trig5_r;
  tail_t              tl_r [5:14];
  logic [16:0]        d5a_r, d5b_r;
  logic [41:0]        v8_r, v9_r, v10_r;
  logic [23:0]        u8_r;
  logic [42:0]        qp11_r, qp12_r;
  logic signed [43+F:0] qs13_r;
  logic signed [RW-1:0] res14_r;
  rcwc_out_t          out_r;

  logic signed [21:0] hfs, n0, n1, n2, n3;
  logic [20:0]        an0, an1, an2, an3;
  logic [30:0]        adx, ady, adx4, ady4;
  logic               ok0, ok1, ok2, ok3, pickx0, picky2;
  logic               ywin;
  logic [2:0]         wall5;
  logic               isx5;
  logic [30:0]        ta6;
  logic [24:0]        qa_w;
  logic [6:0]         ra_w7, rb_w7;
  logic [17:0]        qb_w;
  logic [F:0]         qc_w;
  logic [6:0]         rc_unused;
  logic [42+F:0]      q13;
  logic signed [RW-1:0] t15, c15;

  always_comb begin
    hfs = $signed({7'b0, field_half_r});
    n0 = hfs - 22'(sxq_r);
    n1 = -hfs - 22'(sxq_r);
    n2 = hfs - 22'(syq_r);
    n3 = -hfs - 22'(syq_r);
    an0 = 21'(n0 < 0 ? -n0 : n0);
    an1 = 21'(n1 < 0 ? -n1 : n1);
    an2 = 21'(n2 < 0 ? -n2 : n2);
    an3 = 21'(n3 < 0 ? -n3 : n3);
    adx = 31'(sh_r[2] < 0 ? -sh_r[2] : sh_r[2]);
    ady = 31'(ch_r[2] < 0 ? -ch_r[2] : ch_r[2]);
    ok0 = (adx > TRIG_EPS) && (n0 != 0) && ((n0 > 0) == (sh_r[2] > 0));
    ok1 = (adx > TRIG_EPS) && (n1 != 0) && ((n1 > 0) == (sh_r[2] > 0));
    ok2 = (ady > TRIG_EPS) && (n2 != 0) && ((n2 > 0) == (ch_r[2] > 0));
    ok3 = (ady > TRIG_EPS) && (n3 != 0) && ((n3 > 0) == (ch_r[2] > 0));
    pickx0 = ok0 && !(ok1 && (an1 < an0));
    picky2 = ok2 && !(ok3 && (an3 < an2));
    adx4 = 31'(sh_r[3] < 0 ? -sh_r[3] : sh_r[3]);
    ady4 = 31'(ch_r[3] < 0 ? -ch_r[3] : ch_r[3]);
    ywin = oky_r[4] && (!okx_r[4] || (pry_r < prx_r));
    if (ywin) begin
      wall5 = wy_r[4];
    end else if (okx_r[4]) begin
      wall5 = wx_r[4];
    end else begin
      wall5 = WALL_NONE;
    end
    isx5 = (wall5 == WALL_EAST) || (wall5 == WALL_WEST);
    ta6 = 31'(trig5_r < 0 ? -trig5_r : trig5_r);
    q13 = {qp12_r, {F{1'b0}}} + (43+F)'(qc_w);
    t15 = res14_r + RW'(64'sd536870912);
    c15 = t15 >>> 30;
  end

  rcwc_div127 #(.W(31)) u_div_a (
    .clk(clk), .en1(rdy[PB+6]), .en2(rdy[PB+7]), .x(ta6), .q(qa_w), .r(ra_w7)
  );

  rcwc_div127 #(.W(24)) u_div_b (
    .clk(clk), .en1(rdy[PB+9]), .en2(rdy[PB+10]), .x(u8_r), .q(qb_w), .r(rb_w7)
  );

  rcwc_div127 #(.W(CW)) u_div_c (
    .clk(clk), .en1(rdy[PB+11]), .en2(rdy[PB+12]),
    .x({rb_w7, {F{1'b0}}} + CW'(63)), .q(qc_w), .r(rc_unused)
  );

  always_ff @(posedge clk) begin
    if (rdy[PB]) begin
      psd_r[0] <= rs_w[NC];
      ch_r[0] <= ra_w[NC].neg ? -ra_w[NC].x : ra_w[NC].x;
      sh_r[0] <= ra_w[NC].neg ? -ra_w[NC].y : ra_w[NC].y;
      co0_r   <= rb_w[NC].neg ? -rb_w[NC].x : rb_w[NC].x;
      so0_r   <= rb_w[NC].neg ? -rb_w[NC].y : rb_w[NC].y;
    end
    if (rdy[PB+1]) begin
      psd_r[1] <= psd_r[0];
      ch_r[1] <= ch_r[0];
      sh_r[1] <= sh_r[0];
      pco_r[1] <= 49'(co0_r) * $signed({33'b0, mount_dist_r});
      pso_r[1] <= 49'(so0_r) * $signed({33'b0, mount_dist_r});
    end
    if (rdy[PB+2]) begin
      psd_r[2] <= psd_r[1];
      ch_r[2] <= ch_r[1];
      sh_r[2] <= sh_r[1];
      pco_r[2] <= pco_r[1];
      pso_r[2] <= pso_r[1];
      sxq_r <= 20'(psd_r[1].rx) + 20'(rnd30(pco_r[1]));
      syq_r <= 20'(psd_r[1].ry) + 20'(rnd30(pso_r[1]));
    end
    if (rdy[PB+3]) begin
      psd_r[3] <= psd_r[2];
      ch_r[3] <= ch_r[2];
      sh_r[3] <= sh_r[2];
      pco_r[3] <= pco_r[2];
      pso_r[3] <= pso_r[2];
      okx_r[3] <= ok0 || ok1;
      oky_r[3] <= ok2 || ok3;
      wx_r[3] <= pickx0 ? WALL_EAST : WALL_WEST;
      wy_r[3] <= picky2 ? WALL_NORTH : WALL_SOUTH;
      anx3_r <= pickx0 ? an0 : an1;
      any3_r <= picky2 ? an2 : an3;
    end
    if (rdy[PB+4]) begin
      psd_r[4] <= psd_r[3];
      ch_r[4] <= ch_r[3];
      sh_r[4] <= sh_r[3];
      pco_r[4] <= pco_r[3];
      pso_r[4] <= pso_r[3];
      okx_r[4] <= okx_r[3];
      oky_r[4] <= oky_r[3];
      wx_r[4] <= wx_r[3];
      wy_r[4] <= wy_r[3];
      prx_r <= 52'(anx3_r) * 52'(ady4);
      pry_r <= 52'(any3_r) * 52'(adx4);
    end
    if (rdy[PB+5]) begin
      psd_r[5] <= psd_r[4];
      trig5_r <= isx5 ? sh_r[4] : ch_r[4];
      tl_r[5].rej <= psd_r[4].rej || (wall5 == WALL_NONE);
      tl_r[5].wall <= wall5;
      tl_r[5].tneg <= isx5 ? (sh_r[4] < 0) : (ch_r[4] < 0);
      tl_r[5].wallpos <= ((wall5 == WALL_NORTH) || (wall5 == WALL_EAST)) ?
                         16'(hfs) : -16'(hfs);
      tl_r[5].projoff <= isx5 ? pco_r[4] : pso_r[4];
    end
    if (rdy[PB+6]) begin
      tl_r[6] <= tl_r[5];
      d5a_r <= 17'(psd_r[5].dist_mm) * 17'd5;
    end
    if (rdy[PB+7]) begin
      tl_r[7] <= tl_r[6];
      d5b_r <= d5a_r;
    end
    if (rdy[PB+8]) begin
      tl_r[8] <= tl_r[7];
      u8_r <= 24'(d5b_r) * 24'(ra_w7);
      v8_r <= 42'(d5b_r) * 42'(qa_w);
    end
    if (rdy[PB+9]) begin
      tl_r[9] <= tl_r[8];
      v9_r <= v8_r;
    end
    if (rdy[PB+10]) begin
      tl_r[10] <= tl_r[9];
      v10_r <= v9_r;
    end
    if (rdy[PB+11]) begin
      tl_r[11] <= tl_r[10];
      qp11_r <= 43'(v10_r) + 43'(qb_w);
    end
    if (rdy[PB+12]) begin
      tl_r[12] <= tl_r[11];
      qp12_r <= qp11_r;
    end
    if (rdy[PB+13]) begin
      tl_r[13] <= tl_r[12];
      qs13_r <= tl_r[12].tneg ? -$signed({1'b0, q13}) : $signed({1'b0, q13});
    end
    if (rdy[PB+14]) begin
      tl_r[14] <= tl_r[13];
      res14_r <= (RW'(tl_r[13].wallpos) <<< 30) - RW'(qs13_r) - RW'(tl_r[13].projoff);
    end
    if (rdy[PB+15]) begin
      if (tl_r[14].rej) begin
        out_r.coord_kind  <= KIND_INVALID;
        out_r.coord_value <= 16'sd0;
        out_r.wall_hit    <= WALL_NONE;
      end else begin
        out_r.coord_kind <= ((tl_r[14].wall == WALL_EAST) || (tl_r[14].wall == WALL_WEST)) ?
                            KIND_X : KIND_Y;
        if (c15 > 32767) begin
          out_r.coord_value <= 16'sd32767;
        end else if (c15 < -32768) begin
          out_r.coord_value <= -16'sd32768;
        end else begin
          out_r.coord_value <= 16'(c15);
        end
        out_r.wall_hit <= tl_r[14].wall;
      end
    end
  end

  assign out_data = out_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.coord_kind == KIND_INVALID) |->
      (out_data.coord_value == 16'sd0) && (out_data.wall_hit == WALL_NONE))
    else $error("invalid result carries data");

  a_kind_wall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.coord_kind == KIND_X) |->
      (out_data.wall_hit == WALL_EAST) || (out_data.wall_hit == WALL_WEST))
    else $error("x coordinate from a north or south wall");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled with a free stage");

  a_out_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NS-1] |-> !in_stall)
    else $error("input stalled while output stage empty");

endmodule

// ===== rtl/rcwc_div127.sv =====
module rcwc_div127 import rcwc_pkg::*; #(
  parameter int W = 31
) (
  input  logic           clk,
  input  logic           en1,
  input  logic           en2,
  input  logic [W-1:0]   x,
  output logic [W-7:0]   q,
  output logic [6:0]     r
);

  localparam int QW = W - 6;
  localparam logic [QW-1:0] MUL = QW'((64'd1 << W) / 64'd127);

  logic [W-1:0]    x_r;
  logic [W+QW-1:0] p_r;
  logic [W+QW-1:0] p_nxt;
  logic [QW-1:0]   qe;
  logic [W-1:0]    rf;
  logic [QW-1:0]   q_r, q_nxt;
  logic [6:0]      r_r, r_nxt;

  assign p_nxt = (W+QW)'(x) * (W+QW)'(MUL);

  always_comb begin
    qe = p_r[W+QW-1:W];
    rf = x_r - (W'({qe, 7'b0}) - W'(qe));
    if (rf >= W'(127)) begin
      q_nxt = qe + QW'(1);
      r_nxt = 7'(rf - W'(127));
    end else begin
      q_nxt = qe;
      r_nxt = rf[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x_r <= x;
      p_r <= p_nxt;
    end
    if (en2) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign q = q_r;
  assign r = r_r;

endmodule

// ===== rtl/rcwc_turn.sv =====
module rcwc_turn import rcwc_pkg::*; (
  input  logic               clk,
  input  logic               en1,
  input  logic               en2,
  input  logic               en3,
  input  logic [15:0]        d,
  output logic signed [32:0] z,
  output logic               neg
);

  localparam logic [32:0] RECIP = 33'((64'd1 << 48) / 64'd36000);

  logic [15:0]        d_r;
  logic [48:0]        p_r;
  logic [31:0]        ang_r, ang_nxt;
  logic [31:0]        qe;
  logic [47:0]        nn, rr;
  logic signed [32:0] zs, z_r, z_nxt;
  logic               neg_r, neg_nxt;

  always_comb begin
    qe = 32'((p_r + 49'd32768) >> 16);
    nn = {d_r, 32'b0} + 48'd18000;
    rr = nn - 48'(qe) * 48'd36000;
    ang_nxt = (rr >= 48'd36000) ? qe + 32'd1 : qe;
  end

  always_comb begin
    zs = $signed({ang_r[31], ang_r});
    z_nxt = zs;
    neg_nxt = 1'b0;
    if (zs > 33'sd1073741824) begin
      z_nxt = zs - 33'sd2147483648;
      neg_nxt = 1'b1;
    end else if (zs < -33'sd1073741824) begin
      z_nxt = zs + 33'sd2147483648;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d_r <= d;
      p_r <= 49'(d) * 49'(RECIP);
    end
    if (en2) begin
      ang_r <= ang_nxt;
    end
    if (en3) begin
      z_r <= z_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign z = z_r;
  assign neg = neg_r;

endmodule

// ===== rtl/rcwc_cordic_cell.sv =====
module rcwc_cordic_cell import rcwc_pkg::*; #(
  parameter int I = 0
) (
  input  logic       clk,
  input  logic       en,
  input  rcwc_rot_t  a_in,
  input  rcwc_rot_t  b_in,
  input  rcwc_side_t side_in,
  output rcwc_rot_t  a_out,
  output rcwc_side_t side_out,
  output rcwc_rot_t  b_out
);

  localparam logic signed [32:0] ATAN = $signed({1'b0, atan_turn32(I)});

  rcwc_rot_t  a_r, b_r;
  rcwc_side_t side_r;

  function automatic rcwc_rot_t rot_step(input rcwc_rot_t v);
    rcwc_rot_t o;
    logic signed [31:0] dx, dy;
    dx = v.y >>> I;
    dy = v.x >>> I;
    o = v;
    if (v.z >= 0) begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - ATAN;
    end else begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + ATAN;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= rot_step(a_in);
      b_r <= rot_step(b_in);
      side_r <= side_in;
    end
  end

  assign a_out = a_r;
  assign b_out = b_r;
  assign side_out = side_r;

endmodule
